FILE: hw/rtl/yovl_pkg.sv
// Shared types, constants and helpers for the YUV overlay add/subtract blender.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package yovl_pkg;

    localparam int FIELD_W          = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int NUM_PLANES       = 3;
    localparam int DEPTH_W          = 5;
    localparam int SHIFT_W          = 4;
    localparam int CFG_ADDR_W       = 8;
    localparam int PIPE_DEPTH       = 7;

    localparam int PLANE_Y  = 0;
    localparam int PLANE_CB = 1;
    localparam int PLANE_CR = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN      = 5'd8;
    // pull shift = 5 + (depth - 8) = depth - 3
    localparam logic [DEPTH_W-1:0] PULL_SHIFT_OFS = 5'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_BIT_DEPTH     = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SUBTRACT_MODE = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_MASK      = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OPACITY       = 8'd3;

    localparam logic [DEPTH_W-1:0] RST_BIT_DEPTH = 5'd8;
    localparam logic [FIELD_W-1:0] RST_OPACITY   = 16'd255;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               subtract_mode;
        logic               use_mask;
        logic [FIELD_W-1:0] maxv;
        logic [FIELD_W-1:0] half;
        logic [FIELD_W-1:0] op;
        logic [SHIFT_W-1:0] shift;
        logic [FIELD_W-1:0] over;
    } cfg_t;

    // round(x / (2^depth - 1)) without a divider; valid for x <= maxv^2
    function automatic logic [FIELD_W-1:0] rdiv_max(
        input logic [2*FIELD_W-1:0] x,
        input logic [FIELD_W-1:0]   half,
        input logic [DEPTH_W-1:0]   depth
    );
        logic [2*FIELD_W+1:0] y;
        logic [2*FIELD_W+1:0] t;
        logic [2*FIELD_W+1:0] q;
        y = (2*FIELD_W+2)'(x) + (2*FIELD_W+2)'(half) - (2*FIELD_W+2)'(1);
        t = y + (y >> depth) + (2*FIELD_W+2)'(1);
        q = t >> depth;
        return q[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/yovl_cfg.sv
// Configuration registers and depth-derived constants.
// Depends on yovl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yovl_cfg #(
    parameter int SAMPLE_WIDTH = yovl_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [yovl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [yovl_pkg::FIELD_W-1:0]      cfg_wdata,
    output yovl_pkg::cfg_t                         cfg
);

    localparam logic [yovl_pkg::DEPTH_W-1:0] DEPTH_MAX = yovl_pkg::DEPTH_W'(SAMPLE_WIDTH);

    logic [yovl_pkg::DEPTH_W-1:0] bit_depth_reg;
    logic                         subtract_mode_reg;
    logic                         use_mask_reg;
    logic [yovl_pkg::FIELD_W-1:0] opacity_reg;

    logic [yovl_pkg::DEPTH_W-1:0] depth;
    logic [yovl_pkg::FIELD_W:0]   range;
    logic [yovl_pkg::FIELD_W-1:0] maxv;
    logic [yovl_pkg::SHIFT_W-1:0] shift;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_depth_reg     <= yovl_pkg::RST_BIT_DEPTH;
            subtract_mode_reg <= 1'b0;
            use_mask_reg      <= 1'b0;
            opacity_reg       <= yovl_pkg::RST_OPACITY;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                yovl_pkg::REG_BIT_DEPTH:     bit_depth_reg     <= cfg_wdata[yovl_pkg::DEPTH_W-1:0];
                yovl_pkg::REG_SUBTRACT_MODE: subtract_mode_reg <= cfg_wdata[0];
                yovl_pkg::REG_USE_MASK:      use_mask_reg      <= cfg_wdata[0];
                yovl_pkg::REG_OPACITY:       opacity_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (bit_depth_reg < yovl_pkg::DEPTH_MIN) begin
            depth = yovl_pkg::DEPTH_MIN;
        end else if (bit_depth_reg > DEPTH_MAX) begin
            depth = DEPTH_MAX;
        end else begin
            depth = bit_depth_reg;
        end
        range = (yovl_pkg::FIELD_W+1)'(1) << depth;
        maxv  = yovl_pkg::FIELD_W'(range - (yovl_pkg::FIELD_W+1)'(1));
        shift = yovl_pkg::SHIFT_W'(depth - yovl_pkg::PULL_SHIFT_OFS);

        cfg.depth         = depth;
        cfg.subtract_mode = subtract_mode_reg;
        cfg.use_mask      = use_mask_reg;
        cfg.maxv          = maxv;
        cfg.half          = yovl_pkg::FIELD_W'(1) << (depth - yovl_pkg::DEPTH_W'(1));
        cfg.op            = (opacity_reg > maxv) ? maxv : opacity_reg;
        cfg.shift         = shift;
        cfg.over          = yovl_pkg::FIELD_W'(1) << shift;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/yovl_weight.sv
// Stages A-B: sample masking to depth, mask x opacity product, rounded division
// by max giving the per-plane weight (the opacity itself when use_mask is off). Depends on yovl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yovl_weight #(
    parameter int SAMPLE_WIDTH = yovl_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                             aclk,
    input  wire logic                                             aresetn,
    input  wire yovl_pkg::cfg_t                                   cfg,
    input  wire logic                                             in_valid,
    output logic                                                  in_ready,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][yovl_pkg::FIELD_W-1:0] in_base,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][yovl_pkg::FIELD_W-1:0] in_over,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][yovl_pkg::FIELD_W-1:0] in_mask,
    output logic                                                  out_valid,
    input  wire logic                                             out_ready,
    output logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0]     out_base,
    output logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0]     out_over,
    output logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0]     out_wt
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int NP = yovl_pkg::NUM_PLANES;

    logic                     a_valid_reg;
    logic [NP-1:0][W-1:0]     a_base_reg, a_base_next;
    logic [NP-1:0][W-1:0]     a_over_reg, a_over_next;
    logic [NP-1:0][2*W-1:0]   a_prod_reg, a_prod_next;

    logic                     b_valid_reg;
    logic [NP-1:0][W-1:0]     b_base_reg;
    logic [NP-1:0][W-1:0]     b_over_reg;
    logic [NP-1:0][W-1:0]     b_wt_reg, b_wt_next;

    logic                     en_a, en_b;
    logic [W-1:0]             maxv_w, op_w;
    logic [NP-1:0][W-1:0]     mask_m;

    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;
    assign maxv_w   = cfg.maxv[W-1:0];
    assign op_w     = cfg.op[W-1:0];

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            a_base_next[i] = in_base[i][W-1:0] & maxv_w;
            a_over_next[i] = in_over[i][W-1:0] & maxv_w;
            mask_m[i]      = in_mask[i][W-1:0] & maxv_w;
            a_prod_next[i] = (2*W)'(mask_m[i]) * (2*W)'(op_w);
            b_wt_next[i]   = cfg.use_mask
                ? W'(yovl_pkg::rdiv_max((2*yovl_pkg::FIELD_W)'(a_prod_reg[i]),
                                        cfg.half, cfg.depth))
                : op_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= in_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_base_reg <= a_base_next;
            a_over_reg <= a_over_next;
            a_prod_reg <= a_prod_next;
        end
        if (en_b) begin
            b_base_reg <= a_base_reg;
            b_over_reg <= a_over_reg;
            b_wt_reg   <= b_wt_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_base  = b_base_reg;
    assign out_over  = b_over_reg;
    assign out_wt    = b_wt_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/yovl_scale.sv
// Stages C-D: overlay luma and chroma offsets scaled by weight, rounded
// division by max on the magnitude. Depends on yovl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yovl_scale #(
    parameter int SAMPLE_WIDTH = yovl_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire yovl_pkg::cfg_t                                cfg,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0] in_base,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0] in_over,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0] in_wt,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0]  out_base,
    output logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH:0]    out_term
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int NP = yovl_pkg::NUM_PLANES;

    logic                     c_valid_reg;
    logic [NP-1:0][W-1:0]     c_base_reg;
    logic [NP-1:0]            c_neg_reg, c_neg_next;
    logic [NP-1:0][2*W-1:0]   c_prod_reg, c_prod_next;

    logic                     d_valid_reg;
    logic [NP-1:0][W-1:0]     d_base_reg;
    logic [NP-1:0][W:0]       d_term_reg, d_term_next;

    logic                     en_c, en_d;
    logic [W-1:0]             half_w;
    logic [NP-1:0][W-1:0]     mag, tmag;

    assign en_d     = !d_valid_reg || out_ready;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;
    assign half_w   = cfg.half[W-1:0];

    always_comb begin
        mag[yovl_pkg::PLANE_Y]        = in_over[yovl_pkg::PLANE_Y];
        c_neg_next[yovl_pkg::PLANE_Y] = 1'b0;
        for (int i = yovl_pkg::PLANE_CB; i < NP; i++) begin
            c_neg_next[i] = in_over[i] < half_w;
            mag[i]        = c_neg_next[i] ? (half_w - in_over[i]) : (in_over[i] - half_w);
        end
        for (int i = 0; i < NP; i++) begin
            c_prod_next[i] = (2*W)'(in_wt[i]) * (2*W)'(mag[i]);
            tmag[i] = W'(yovl_pkg::rdiv_max((2*yovl_pkg::FIELD_W)'(c_prod_reg[i]),
                                            cfg.half, cfg.depth));
            d_term_next[i] = c_neg_reg[i] ? ((W+1)'(0) - {1'b0, tmag[i]}) : {1'b0, tmag[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (en_c) c_valid_reg <= in_valid;
            if (en_d) d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_base_reg <= in_base;
            c_neg_reg  <= c_neg_next;
            c_prod_reg <= c_prod_next;
        end
        if (en_d) begin
            d_base_reg <= c_base_reg;
            d_term_reg <= d_term_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_base  = d_base_reg;
    assign out_term  = d_term_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/yovl_mix.sv
// Stages E-G: add or subtract, overshoot detection, chroma pull toward
// neutral, luma clip and chroma clamp; stage G is the output register.
// Depends on yovl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yovl_mix #(
    parameter int SAMPLE_WIDTH = yovl_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire yovl_pkg::cfg_t                                cfg,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0] in_base,
    input  wire logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH:0]   in_term,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [yovl_pkg::NUM_PLANES-1:0][SAMPLE_WIDTH-1:0]  out_pix
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int NP = yovl_pkg::NUM_PLANES;
    localparam int NC = NP - 1;

    function automatic logic [W-1:0] clamp_max(input logic signed [W+1:0] v,
                                               input logic [W-1:0] maxv);
        logic signed [W+1:0] hi;
        hi = $signed({2'b00, maxv});
        if (v < 0) return '0;
        if (v > hi) return maxv;
        return v[W-1:0];
    endfunction

    // stage E
    logic                     e_valid_reg;
    logic [W-1:0]             e_y_reg, e_y_next;
    logic signed [W+1:0]      e_c_reg [NC];
    logic signed [W+1:0]      e_c_next [NC];
    logic                     e_pull_reg, e_pull_next;
    logic [W-3:0]             e_k_reg, e_k_next;

    // stage F
    logic                     f_valid_reg;
    logic [W-1:0]             f_y_reg;
    logic signed [W+1:0]      f_c_reg [NC];
    logic signed [2*W:0]      f_prod_reg [NC];
    logic signed [2*W:0]      f_prod_next [NC];
    logic [2*W-1:0]           f_hterm_reg, f_hterm_next;
    logic                     f_pull_reg;

    // stage G
    logic                     g_valid_reg;
    logic [NP-1:0][W-1:0]     g_pix_reg, g_pix_next;

    logic                     en_e, en_f, en_g;
    logic [W-1:0]             maxv_w;
    logic [W-3:0]             over_w;
    logic signed [W+1:0]      ysum;
    logic signed [W+1:0]      bext [NP];
    logic signed [W+1:0]      text [NP];
    logic signed [W+2:0]      kraw, mneg, over_s;
    logic signed [2*W:0]      ua, ka;
    logic signed [2*W+1:0]    psum [NC];
    logic signed [2*W+1:0]    pshr [NC];
    logic signed [W+1:0]      cval [NC];

    assign en_g     = !g_valid_reg || out_ready;
    assign en_f     = !f_valid_reg || en_g;
    assign en_e     = !e_valid_reg || en_f;
    assign in_ready = en_e;
    assign maxv_w   = cfg.maxv[W-1:0];
    assign over_w   = cfg.over[W-3:0];

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            bext[i] = {2'b00, in_base[i]};
            text[i] = (W+2)'($signed(in_term[i]));
        end
        ysum = cfg.subtract_mode ? (bext[yovl_pkg::PLANE_Y] - text[yovl_pkg::PLANE_Y])
                                 : (bext[yovl_pkg::PLANE_Y] + text[yovl_pkg::PLANE_Y]);
        for (int j = 0; j < NC; j++) begin
            e_c_next[j] = cfg.subtract_mode ? (bext[j+1] - text[j+1]) : (bext[j+1] + text[j+1]);
        end
        over_s = $signed({5'b00000, over_w});
        kraw   = $signed({3'b000, maxv_w}) + $signed((W+3)'(1)) + over_s - (W+3)'(ysum);
        mneg   = -((W+3)'(ysum));
        if (cfg.subtract_mode) begin
            e_pull_next = ysum < 0;
            e_k_next    = (mneg > over_s) ? '0 : (over_w - mneg[W-3:0]);
        end else begin
            e_pull_next = ysum > $signed({2'b00, maxv_w});
            e_k_next    = (kraw < 0) ? '0 : kraw[W-3:0];
        end
        e_y_next = clamp_max(ysum, maxv_w);
    end

    always_comb begin
        ka = (2*W+1)'(e_k_reg);
        for (int j = 0; j < NC; j++) begin
            ua             = (2*W+1)'(e_c_reg[j]);
            f_prod_next[j] = ua * ka;
        end
        f_hterm_next = (2*W)'(over_w - e_k_reg) << (cfg.depth - yovl_pkg::DEPTH_W'(1));
    end

    always_comb begin
        g_pix_next[yovl_pkg::PLANE_Y] = f_y_reg;
        for (int j = 0; j < NC; j++) begin
            psum[j] = $signed({2'b00, f_hterm_reg}) + (2*W+2)'(f_prod_reg[j]);
            pshr[j] = psum[j] >>> cfg.shift;
            cval[j] = f_pull_reg ? $signed(pshr[j][W+1:0]) : f_c_reg[j];
            g_pix_next[j+1] = clamp_max(cval[j], maxv_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else begin
            if (en_e) e_valid_reg <= in_valid;
            if (en_f) f_valid_reg <= e_valid_reg;
            if (en_g) g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_e) begin
            e_y_reg    <= e_y_next;
            e_c_reg    <= e_c_next;
            e_pull_reg <= e_pull_next;
            e_k_reg    <= e_k_next;
        end
        if (en_f) begin
            f_y_reg     <= e_y_reg;
            f_c_reg     <= e_c_reg;
            f_prod_reg  <= f_prod_next;
            f_hterm_reg <= f_hterm_next;
            f_pull_reg  <= e_pull_reg;
        end
        if (en_g) begin
            g_pix_reg <= g_pix_next;
        end
    end

    assign out_valid = g_valid_reg;
    assign out_pix   = g_pix_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/yuv_overlay_add_subtract.sv
// Top level of the YUV overlay add/subtract blender.
// Depends on yovl_pkg, yovl_cfg, yovl_weight, yovl_scale, yovl_mix.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tdata: base, overlay, mask pixel
//  m_*       out        m_tvalid/m_tready   m_tdata: blended pixel
//  cfg_*     in         cfg_valid/cfg_ready cfg_addr, cfg_wdata
//
// One pixel per clock while m_tready does not stall the output; register stages A..G
// hold the two product-and-divide passes and the pull multiply.
// aresetn is synchronous; it clears all valid bits and the config registers.
// Each stage advances when empty or when the next one advances, so bubbles
// are squeezed out while m_tready is low; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module yuv_overlay_add_subtract #(
    parameter int SAMPLE_WIDTH = yovl_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // base_luma, base_cb, base_cr, over_luma, over_cb, over_cr,
    // mask_luma, mask_cb, mask_cr; 16 bits each, lowest first
    input  wire logic [9*yovl_pkg::FIELD_W-1:0]        s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // out_luma, out_cb, out_cr; 16 bits each, lowest first
    output logic [3*yovl_pkg::FIELD_W-1:0]             m_tdata,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [yovl_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [yovl_pkg::FIELD_W-1:0]          cfg_wdata
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int NP = yovl_pkg::NUM_PLANES;
    localparam int FW = yovl_pkg::FIELD_W;

    yovl_pkg::cfg_t cfg;

    logic [NP-1:0][FW-1:0] in_base, in_over, in_mask;

    logic                 w_valid, w_ready;
    logic [NP-1:0][W-1:0] w_base, w_over, w_wt;
    logic                 t_valid, t_ready;
    logic [NP-1:0][W-1:0] t_base;
    logic [NP-1:0][W:0]   t_term;
    logic [NP-1:0][W-1:0] o_pix;

    assign in_base = s_tdata[NP*FW-1:0];
    assign in_over = s_tdata[2*NP*FW-1:NP*FW];
    assign in_mask = s_tdata[3*NP*FW-1:2*NP*FW];

    yovl_cfg #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    yovl_weight #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_base   (in_base),
        .in_over   (in_over),
        .in_mask   (in_mask),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .out_base  (w_base),
        .out_over  (w_over),
        .out_wt    (w_wt)
    );

    yovl_scale #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_base   (w_base),
        .in_over   (w_over),
        .in_wt     (w_wt),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_base  (t_base),
        .out_term  (t_term)
    );

    yovl_mix #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_base   (t_base),
        .in_term   (t_term),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (o_pix)
    );

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            m_tdata[i*FW +: FW] = FW'(o_pix[i]);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/yovl_checker.sv
// Port-level checker for yuv_overlay_add_subtract, bound to the top level.
// Depends on yovl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yovl_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [3*yovl_pkg::FIELD_W-1:0] m_tdata
);

    logic [3:0] inflight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 4'd0)
        else $error("output transaction without a pending input");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'(yovl_pkg::PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind yuv_overlay_add_subtract yovl_checker u_yovl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for yuv_overlay_add_subtract: blends streamed YUV pixels and compares each result
// with a behavioral blend model or a hand-written expected value, across depths, modes and opacities.
// Depends on yovl_pkg and the yuv_overlay_add_subtract RTL.
`timescale 1ns / 1ps

module tb;

    localparam int FW = yovl_pkg::FIELD_W;
    localparam int DW = yovl_pkg::DEPTH_W;
    localparam int AW = yovl_pkg::CFG_ADDR_W;
    localparam int SAMPLE_W = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTINGS_PER_MODE = 6;
    localparam int ITEMS_PER_SETTING = 39;
    localparam logic [AW-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [AW-1:0] REG_SPARE_HI = 8'hFF;

    typedef struct packed {
        logic [FW-1:0] mask_cr;
        logic [FW-1:0] mask_cb;
        logic [FW-1:0] mask_luma;
        logic [FW-1:0] over_cr;
        logic [FW-1:0] over_cb;
        logic [FW-1:0] over_luma;
        logic [FW-1:0] base_cr;
        logic [FW-1:0] base_cb;
        logic [FW-1:0] base_luma;
    } pixel_in_t;

    typedef struct packed {
        logic [FW-1:0] out_cr;
        logic [FW-1:0] out_cb;
        logic [FW-1:0] out_luma;
    } pixel_out_t;

    typedef struct {
        logic [DW-1:0] depth;
        logic          sub;
        logic          msk;
        logic [FW-1:0] opac;
        pixel_in_t     px;
        bit            typed;
        pixel_out_t    want;
    } row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [9*FW-1:0]             s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [3*FW-1:0]             m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [AW-1:0]               cfg_addr = '0;
    logic [FW-1:0]               cfg_wdata = '0;

    // register shadow, tracked at each accepted config transaction
    logic [DW-1:0] cfg_depth = yovl_pkg::RST_BIT_DEPTH;
    logic          cfg_sub = 1'b0;
    logic          cfg_mask = 1'b0;
    logic [FW-1:0] cfg_opacity = yovl_pkg::RST_OPACITY;

    pixel_out_t pending_pixels[$];
    bit         has_typed = 1'b0;
    pixel_out_t typed_pixel = '0;
    int         fault_count = 0;
    int         result_count = 0;
    int         idle_cycles = 0;
    int         src_idle_pct = 14;
    int         sink_idle_pct = 56;

    yuv_overlay_add_subtract #(.SAMPLE_WIDTH(SAMPLE_W)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic int eff_depth(input logic [DW-1:0] dv);
        int d;
        d = dv;
        if (d < 8) d = 8;
        if (d > SAMPLE_W) d = SAMPLE_W;
        return d;
    endfunction

    function automatic longint round_div(input longint x, input longint mx);
        return (x + mx / 2) / mx;
    endfunction

    function automatic longint weigh_offset(input longint dv, input longint w, input longint mx);
        if (dv >= 0) return round_div(w * dv, mx);
        return -round_div(w * -dv, mx);
    endfunction

    function automatic logic [FW-1:0] clamp_sample(input longint val, input longint mx);
        if (val < 0) return '0;
        if (val > mx) return FW'(mx);
        return FW'(val);
    endfunction

    function automatic pixel_out_t blend_pixel(input pixel_in_t px);
        int d;
        int sh;
        longint mx, half, over, op, by, bu, bv, oy, ou, ov, my, mu, mv;
        longint ey, eu, ev, ty, tu, tv, y, u, v, m;
        pixel_out_t r;
        d = eff_depth(cfg_depth);
        sh = d - 3;
        mx = (longint'(1) << d) - 1;
        half = longint'(1) << (d - 1);
        over = longint'(1) << sh;
        op = (longint'(cfg_opacity) > mx) ? mx : longint'(cfg_opacity);
        by = longint'(px.base_luma) & mx;
        bu = longint'(px.base_cb) & mx;
        bv = longint'(px.base_cr) & mx;
        oy = longint'(px.over_luma) & mx;
        ou = longint'(px.over_cb) & mx;
        ov = longint'(px.over_cr) & mx;
        my = longint'(px.mask_luma) & mx;
        mu = longint'(px.mask_cb) & mx;
        mv = longint'(px.mask_cr) & mx;
        if (cfg_mask) begin
            ey = round_div(my * op, mx);
            eu = round_div(mu * op, mx);
            ev = round_div(mv * op, mx);
        end else begin
            ey = op;
            eu = op;
            ev = op;
        end
        tu = weigh_offset(ou - half, eu, mx);
        tv = weigh_offset(ov - half, ev, mx);
        ty = round_div(oy * ey, mx);
        if (!cfg_sub) begin
            y = by + ty;
            u = bu + tu;
            v = bv + tv;
            if (y > mx) begin
                m = mx + 1 + over - y;
                if (m < 0) m = 0;
                u = (u * m + half * (over - m)) >>> sh;
                v = (v * m + half * (over - m)) >>> sh;
                y = mx;
            end
        end else begin
            y = by - ty;
            u = bu - tu;
            v = bv - tv;
            if (y < 0) begin
                m = -y;
                if (m > over) m = over;
                u = (u * (over - m) + half * m) >>> sh;
                v = (v * (over - m) + half * m) >>> sh;
                y = 0;
            end
        end
        r.out_luma = clamp_sample(y, mx);
        r.out_cb = clamp_sample(u, mx);
        r.out_cr = clamp_sample(v, mx);
        return r;
    endfunction

    function automatic logic [FW-1:0] with_low(input logic [FW-1:0] field,
                                               input logic [FW-1:0] low,
                                               input logic [FW-1:0] mx);
        return (field & ~mx) | (low & mx);
    endfunction

    function automatic pixel_in_t mk_pixel(input int bl, input int bc, input int br,
                                           input int ol, input int oc, input int orr,
                                           input int ml, input int mc, input int mr);
        pixel_in_t px;
        px.base_luma = FW'(bl);
        px.base_cb = FW'(bc);
        px.base_cr = FW'(br);
        px.over_luma = FW'(ol);
        px.over_cb = FW'(oc);
        px.over_cr = FW'(orr);
        px.mask_luma = FW'(ml);
        px.mask_cb = FW'(mc);
        px.mask_cr = FW'(mr);
        return px;
    endfunction

    function automatic pixel_out_t mk_out(input int l, input int cb, input int cr);
        pixel_out_t r;
        r.out_luma = FW'(l);
        r.out_cb = FW'(cb);
        r.out_cr = FW'(cr);
        return r;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // monitor: config shadow, prediction on input transactions, checks on results
    always @(posedge aclk) begin
        pixel_out_t got;
        pixel_out_t want;
        if (!aresetn) begin
            cfg_depth = yovl_pkg::RST_BIT_DEPTH;
            cfg_sub = 1'b0;
            cfg_mask = 1'b0;
            cfg_opacity = yovl_pkg::RST_OPACITY;
            idle_cycles <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    yovl_pkg::REG_BIT_DEPTH:     cfg_depth = cfg_wdata[DW-1:0];
                    yovl_pkg::REG_SUBTRACT_MODE: cfg_sub = cfg_wdata[0];
                    yovl_pkg::REG_USE_MASK:      cfg_mask = cfg_wdata[0];
                    yovl_pkg::REG_OPACITY:       cfg_opacity = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pending_pixels.push_back(has_typed ? typed_pixel
                                                   : blend_pixel(pixel_in_t'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                got = pixel_out_t'(m_tdata);
                if (pending_pixels.size() == 0) begin
                    report_fault($sformatf("result %0d with no pixel pending: %h",
                                           result_count, m_tdata));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.out_luma !== want.out_luma)
                        report_fault($sformatf("result %0d out_luma %h, expected %h",
                                               result_count, got.out_luma, want.out_luma));
                    if (got.out_cb !== want.out_cb)
                        report_fault($sformatf("result %0d out_cb %h, expected %h",
                                               result_count, got.out_cb, want.out_cb));
                    if (got.out_cr !== want.out_cr)
                        report_fault($sformatf("result %0d out_cr %h, expected %h",
                                               result_count, got.out_cr, want.out_cr));
                end
                result_count++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("tb failed");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic push_pixel(input pixel_in_t px, input bit typed, input pixel_out_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = px;
        has_typed = typed;
        typed_pixel = want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [AW-1:0] idx, input logic [FW-1:0] val);
        cfg_valid = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_mode(input logic [DW-1:0] dv, input logic sub, input logic msk,
                            input logic [FW-1:0] opac);
        wait_drained();
        write_reg(yovl_pkg::REG_BIT_DEPTH, FW'(dv));
        write_reg(yovl_pkg::REG_SUBTRACT_MODE, FW'(sub));
        write_reg(yovl_pkg::REG_USE_MASK, FW'(msk));
        write_reg(yovl_pkg::REG_OPACITY, opac);
        cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        row_t          dir_rows[$];
        pixel_in_t     px;
        logic [DW-1:0] dv;
        logic [FW-1:0] opac;
        logic [FW-1:0] mx;
        logic [FW-1:0] band;
        int            d;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // writes to unmapped indexes must leave the reset settings alone
        write_reg(REG_SPARE_LO, 16'h0010);
        write_reg(REG_SPARE_HI, 16'h0001);
        cfg_valid = 1'b0;

        // reset settings: depth 8, add, no mask, opacity 255
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b0, 16'd255,
            mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b0, 16'd255,
            mk_pixel(16, 128, 128, 0, 128, 128, 0, 0, 0), 1'b1, mk_out(16, 128, 128)});
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b0, 16'd255,
            mk_pixel('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF),
            1'b1, mk_out(255, 128, 128)});
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b0, 16'd255,
            mk_pixel('h1F10, 'hAB80, 'h5580, 'h0020, 'h7F80, 'hFF80, 'hFFFF, 0, 'h1234),
            1'b1, mk_out('h30, 'h80, 'h80)});
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b0, 16'd255,
            mk_pixel(50, 100, 150, 60, 128, 128, 0, 0, 0), 1'b1, mk_out(110, 100, 150)});
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b0, 16'd255,
            mk_pixel(240, 200, 20, 30, 255, 0, 0, 0, 0), 1'b0, mk_out(0, 0, 0)});
        // subtract, partial and full undershoot, negative chroma before the pull
        dir_rows.push_back(row_t'{5'd8, 1'b1, 1'b0, 16'd255,
            mk_pixel(20, 0, 3, 30, 255, 250, 0, 0, 0), 1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd8, 1'b1, 1'b0, 16'd255,
            mk_pixel(5, 10, 250, 255, 0, 255, 0, 0, 0), 1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd8, 1'b1, 1'b0, 16'd255,
            mk_pixel(200, 90, 170, 40, 140, 100, 0, 0, 0), 1'b0, mk_out(0, 0, 0)});
        // opacity above max with mask, and a masked subtract at opacity 100
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b1, 16'hFFFF,
            mk_pixel(100, 100, 100, 200, 0, 255, 0, 255, 128), 1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd8, 1'b0, 1'b1, 16'hFFFF,
            mk_pixel(230, 60, 190, 50, 250, 3, 255, 255, 255), 1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd8, 1'b1, 1'b1, 16'd100,
            mk_pixel(10, 128, 128, 250, 0, 255, 200, 77, 130), 1'b0, mk_out(0, 0, 0)});
        // depth below, above and inside the legal range
        dir_rows.push_back(row_t'{5'd0, 1'b0, 1'b0, 16'd255,
            mk_pixel('h01F0, 'h0160, 'h02A0, 'h0130, 'h01F0, 'h0010, 0, 0, 0),
            1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd31, 1'b0, 1'b0, 16'hFFFF,
            mk_pixel('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF),
            1'b1, mk_out('hFFFF, 'h8000, 'h8000)});
        dir_rows.push_back(row_t'{5'd31, 1'b0, 1'b0, 16'hFFFF,
            mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd17, 1'b1, 1'b1, 16'h8000,
            mk_pixel(900, 30000, 41000, 1500, 65000, 100, 65535, 12345, 0),
            1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd16, 1'b0, 1'b0, 16'd0,
            mk_pixel(1234, 40000, 25000, 'hBEEF, 'h1357, 'hF00D, 0, 0, 0),
            1'b1, mk_out(1234, 40000, 25000)});
        dir_rows.push_back(row_t'{5'd12, 1'b0, 1'b0, 16'd4095,
            mk_pixel(4000, 3000, 500, 200, 4095, 0, 0, 0, 0), 1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd9, 1'b1, 1'b0, 16'd1000,
            mk_pixel(12, 300, 260, 500, 17, 511, 0, 0, 0), 1'b0, mk_out(0, 0, 0)});
        dir_rows.push_back(row_t'{5'd15, 1'b0, 1'b1, 16'd20000,
            mk_pixel(32000, 5000, 28000, 9000, 31000, 222, 32767, 16000, 1),
            1'b0, mk_out(0, 0, 0)});

        foreach (dir_rows[i]) begin
            if (dir_rows[i].depth != cfg_depth || dir_rows[i].sub != cfg_sub ||
                dir_rows[i].msk != cfg_mask || dir_rows[i].opac != cfg_opacity)
                set_mode(dir_rows[i].depth, dir_rows[i].sub, dir_rows[i].msk, dir_rows[i].opac);
            push_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 56 : 0;
            sink_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 14 : 0;
            for (int k = 0; k < SETTINGS_PER_MODE; k++) begin
                if (k == 0) dv = 5'd8;
                else if (k == 1) dv = 5'd16;
                else if ($urandom_range(7) == 0) dv = DW'($urandom_range(31));
                else dv = DW'($urandom_range(16, 8));
                d = eff_depth(dv);
                mx = FW'((32'd1 << d) - 1);
                band = FW'(32'd1 << (d - 2));
                case ($urandom_range(4))
                    0: opac = '0;
                    1: opac = mx;
                    2: opac = 16'hFFFF;
                    default: opac = FW'($urandom_range(mx));
                endcase
                set_mode(dv, 1'($urandom_range(1)), 1'($urandom_range(1)), opac);
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    px = pixel_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                    case ($urandom_range(3))
                        1: begin
                            // luma straddling the top overshoot band
                            px.base_luma = with_low(px.base_luma,
                                                    mx - FW'($urandom_range(band)), mx);
                            px.over_luma = with_low(px.over_luma,
                                                    FW'($urandom_range(band)), mx);
                        end
                        2: begin
                            // luma straddling zero when subtracting
                            px.base_luma = with_low(px.base_luma,
                                                    FW'($urandom_range(band)), mx);
                            px.over_luma = with_low(px.over_luma,
                                                    FW'($urandom_range(band)), mx);
                        end
                        3: begin
                            px.base_cb = with_low(px.base_cb, $urandom_range(1) ? mx : '0, mx);
                            px.base_cr = with_low(px.base_cr, $urandom_range(1) ? mx : '0, mx);
                            px.over_cb = with_low(px.over_cb, $urandom_range(1) ? mx : '0, mx);
                            px.over_cr = with_low(px.over_cr, $urandom_range(1) ? mx : '0, mx);
                        end
                        default: ;
                    endcase
                    if ($urandom_range(99) == 0) wait_drained();
                    push_pixel(px, 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (yovl_pkg::PIPE_DEPTH + 4) @(negedge aclk);
        if (pending_pixels.size() != 0)
            report_fault($sformatf("%0d pixels never came out", pending_pixels.size()));
        if (fault_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
